FILE: design/eiah_pkg.sv
// Shared types and codes for the edge inter-arrival histogram unit.
`default_nettype none
package eiah_pkg;

    typedef enum logic [1:0] {
        KIND_CYCLE = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_MOVE  = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

    localparam logic [7:0] BIN_WIDTH_RESET = 8'd10;
    localparam logic       REG_BIN_WIDTH   = 1'b0;

    typedef struct packed {
        kind_t        kind;
        logic [7:0]   edge_req;
        logic [15:0]  items_moved;
        logic [63:0]  cycle_value;
        logic [15:0]  clock_domain;
        logic [7:0]   bin_select;
    } in_item_t;

    typedef struct packed {
        logic [31:0]  traversal_total;
        logic [63:0]  gap_sum;
        logic [7:0]   bin_hit;
        logic         gap_counted;
        logic [31:0]  bin_count;
    } out_item_t;

    typedef struct packed {
        logic [31:0]  cnt;
        logic [63:0]  last;
        logic [63:0]  gtot;
    } edge_entry_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLR,
        ST_ERD,
        ST_GAP,
        ST_DIV,
        ST_BRD,
        ST_B0,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

FILE: design/eiah_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
`default_nettype none
module eiah_ram #(
    parameter int W = 32,
    parameter int D = 256,
    parameter int AW = (D > 1) ? $clog2(D) : 1
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [W-1:0]  wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [W-1:0]  rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: design/eiah_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module eiah_div #(
    parameter int QW = 8,
    parameter int DW = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [QW-1:0] dividend,
    input  wire logic [DW-1:0] divisor,
    output logic               done,
    output logic      [QW-1:0] quotient
);

    localparam int RW = ((QW > DW) ? QW : DW) + 1;
    localparam int CW = $clog2(QW + 1);

    logic [RW-1:0] rem_reg, rem_next;
    logic [QW-1:0] q_reg, q_next;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;
    logic [RW-1:0] trial;
    logic          qbit;

    always_comb
    begin
        trial = {rem_reg[RW-2:0], q_reg[QW-1]};
        qbit  = (trial >= RW'(d_reg));
        rem_next = qbit ? (trial - RW'(d_reg)) : trial;
        q_next = (q_reg << 1) | QW'(qbit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(QW - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= dividend;
            d_reg   <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
`default_nettype wire

FILE: design/edge_interarrival_histogram_unit.sv
// Top level of the edge inter-arrival histogram unit: control and memories.
//
//  Channel   Signals                         Transaction
//  command   start, busy, item               start high while busy low
//  result    done, result                    done high for one cycle
//  config    psel, penable, pwrite, paddr,   psel, penable, pwrite high
//            pwdata, prdata, pready
//
// After reset a clearing pass writes every bin and edge entry with busy
// high. A cycle update or an item on an edge out of range goes straight to
// done, a read or a move on an unseen edge reads the edge entry first, a
// move with a gap also runs the iterative divider and the bin
// read-modify-write, plus a bin 0 update when extra items go to bin 0 apart
// from a nonzero hit bin, and a clear writes one bin a cycle.
// The result cannot be stalled; busy stays high until done has pulsed.
`default_nettype none
module edge_interarrival_histogram_unit #(
    parameter int NUM_EDGES = 256,
    parameter int MAX_GAP   = 200
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire eiah_pkg::in_item_t  item,
    output logic                     done,
    output eiah_pkg::out_item_t      result,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready
);

    localparam int NUM_BINS  = MAX_GAP + 1;
    localparam int BIN_DEPTH = NUM_EDGES * NUM_BINS;
    localparam int EAW = (NUM_EDGES > 1) ? $clog2(NUM_EDGES) : 1;
    localparam int BAW = $clog2(BIN_DEPTH);
    localparam int BNW = $clog2(NUM_BINS);

    eiah_pkg::state_t      state_reg, state_next;
    logic [7:0]            bin_width_reg;
    logic [63:0]           now_reg;
    logic [7:0]            edge_reg;
    logic [15:0]           moved_reg;
    logic [31:0]           cnt_reg;
    logic [63:0]           gtot_reg;
    logic [63:0]           gap_reg;
    logic [BNW-1:0]        hit_reg;
    logic [BNW-1:0]        bcnt_reg;
    logic [BAW-1:0]        init_reg;
    logic [BNW-1:0]        sel_reg;
    eiah_pkg::out_item_t   res_reg;
    eiah_pkg::kind_t       kind_reg;

    logic                  edge_we;
    logic [EAW-1:0]        edge_waddr, edge_raddr;
    eiah_pkg::edge_entry_t edge_wdata, edge_rdata;
    logic                  bin_we;
    logic [BAW-1:0]        bin_waddr, bin_raddr;
    logic [31:0]           bin_wdata, bin_rdata;

    logic                  accept;
    logic                  in_range;
    logic [BNW-1:0]        sel_sat;
    logic [BAW-1:0]        item_base, reg_base;
    logic [7:0]            w_eff;
    logic [BNW-1:0]        capped;
    logic                  div_start, div_done;
    logic [BNW-1:0]        div_q;
    logic [31:0]           hit_add;
    logic [31:0]           hit_sum;

    assign accept   = start && !busy;
    assign busy     = (state_reg != eiah_pkg::ST_IDLE);
    assign in_range = (32'(item.edge_req) < NUM_EDGES);
    assign sel_sat  = (32'(item.bin_select) > MAX_GAP) ? BNW'(MAX_GAP)
                                                      : BNW'(item.bin_select);
    assign item_base = BAW'(32'(item.edge_req) * NUM_BINS);
    assign reg_base  = BAW'(32'(edge_reg) * NUM_BINS);
    assign w_eff     = (bin_width_reg == 8'd0) ? 8'd1 : bin_width_reg;
    assign capped    = (gap_reg > 64'(MAX_GAP)) ? BNW'(MAX_GAP) : BNW'(gap_reg);
    // A gap into bin 0 takes the extra items of the transaction as well.
    assign hit_add = (hit_reg != '0) ? 32'd1
                   : ((moved_reg > 16'd1) ? 32'(moved_reg) : 32'd1);
    assign hit_sum = bin_rdata + hit_add;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == eiah_pkg::REG_BIN_WIDTH) ? {24'd0, bin_width_reg}
                                                          : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_width_reg <= eiah_pkg::BIN_WIDTH_RESET;
        end
        else if (psel && penable && pwrite && pready
                 && paddr[2] == eiah_pkg::REG_BIN_WIDTH)
        begin
            bin_width_reg <= pwdata[7:0];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            eiah_pkg::ST_INIT:
            begin
                if (init_reg == BAW'(BIN_DEPTH - 1))
                begin
                    state_next = eiah_pkg::ST_IDLE;
                end
            end
            eiah_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.kind == eiah_pkg::KIND_CYCLE || !in_range)
                    begin
                        state_next = eiah_pkg::ST_DONE;
                    end
                    else if (item.kind == eiah_pkg::KIND_CLEAR)
                    begin
                        state_next = eiah_pkg::ST_CLR;
                    end
                    else
                    begin
                        state_next = eiah_pkg::ST_ERD;
                    end
                end
            end
            eiah_pkg::ST_CLR:
            begin
                if (bcnt_reg == BNW'(NUM_BINS - 1))
                begin
                    state_next = eiah_pkg::ST_DONE;
                end
            end
            eiah_pkg::ST_ERD:
            begin
                if (kind_reg == eiah_pkg::KIND_READ || edge_rdata.last == 64'd0)
                begin
                    state_next = eiah_pkg::ST_DONE;
                end
                else
                begin
                    state_next = eiah_pkg::ST_GAP;
                end
            end
            eiah_pkg::ST_GAP: state_next = eiah_pkg::ST_DIV;
            eiah_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = eiah_pkg::ST_BRD;
                end
            end
            eiah_pkg::ST_BRD:
            begin
                if (hit_reg != '0 && moved_reg > 16'd1)
                begin
                    state_next = eiah_pkg::ST_B0;
                end
                else
                begin
                    state_next = eiah_pkg::ST_DONE;
                end
            end
            eiah_pkg::ST_B0:   state_next = eiah_pkg::ST_DONE;
            eiah_pkg::ST_DONE: state_next = eiah_pkg::ST_IDLE;
            default:           state_next = eiah_pkg::ST_IDLE;
        endcase
    end

    // Memory controls.
    always_comb
    begin
        edge_we    = 1'b0;
        edge_waddr = EAW'(edge_reg);
        edge_wdata = '0;
        edge_raddr = EAW'(item.edge_req);
        bin_we     = 1'b0;
        bin_waddr  = reg_base;
        bin_wdata  = 32'd0;
        bin_raddr  = item_base + BAW'(sel_sat);
        div_start  = 1'b0;
        case (state_reg)
            eiah_pkg::ST_INIT:
            begin
                bin_we    = 1'b1;
                bin_waddr = init_reg;
                if (32'(init_reg) < NUM_EDGES)
                begin
                    edge_we    = 1'b1;
                    edge_waddr = EAW'(init_reg);
                end
            end
            eiah_pkg::ST_CLR:
            begin
                bin_we    = 1'b1;
                bin_waddr = reg_base + BAW'(bcnt_reg);
                edge_we   = 1'b1;
            end
            eiah_pkg::ST_ERD:
            begin
                if (kind_reg == eiah_pkg::KIND_MOVE && edge_rdata.last == 64'd0)
                begin
                    edge_we    = 1'b1;
                    edge_wdata = '{cnt: edge_rdata.cnt + 32'(moved_reg),
                                   last: now_reg, gtot: edge_rdata.gtot};
                end
            end
            eiah_pkg::ST_GAP:
            begin
                edge_we    = 1'b1;
                edge_wdata = '{cnt: cnt_reg, last: now_reg, gtot: gtot_reg + gap_reg};
                div_start  = 1'b1;
            end
            eiah_pkg::ST_DIV:
            begin
                bin_raddr = reg_base + BAW'(div_q);
            end
            eiah_pkg::ST_BRD:
            begin
                bin_we    = 1'b1;
                bin_waddr = reg_base + BAW'(hit_reg);
                bin_wdata = hit_sum;
                bin_raddr = reg_base;
            end
            eiah_pkg::ST_B0:
            begin
                bin_we    = 1'b1;
                bin_waddr = reg_base;
                bin_wdata = bin_rdata + 32'(moved_reg) - 32'd1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= eiah_pkg::ST_INIT;
            init_reg  <= '0;
            now_reg   <= 64'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == eiah_pkg::ST_INIT)
            begin
                init_reg <= init_reg + 1'b1;
            end
            if (accept && item.kind == eiah_pkg::KIND_CYCLE && item.clock_domain == 16'd0)
            begin
                now_reg <= item.cycle_value;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            eiah_pkg::ST_IDLE:
            begin
                kind_reg  <= item.kind;
                edge_reg  <= item.edge_req;
                moved_reg <= item.items_moved;
                sel_reg   <= sel_sat;
                bcnt_reg  <= '0;
                res_reg   <= '0;
            end
            eiah_pkg::ST_CLR:
            begin
                bcnt_reg <= bcnt_reg + 1'b1;
            end
            eiah_pkg::ST_ERD:
            begin
                cnt_reg  <= edge_rdata.cnt + 32'(moved_reg);
                gtot_reg <= edge_rdata.gtot;
                gap_reg  <= now_reg - edge_rdata.last;
                if (kind_reg == eiah_pkg::KIND_READ)
                begin
                    // The read bin was saturated when the transaction was taken.
                    res_reg <= '{traversal_total: edge_rdata.cnt,
                                 gap_sum: edge_rdata.gtot,
                                 bin_hit: 8'(sel_reg),
                                 gap_counted: 1'b0, bin_count: bin_rdata};
                end
                else
                begin
                    res_reg <= '{traversal_total: edge_rdata.cnt + 32'(moved_reg),
                                 gap_sum: edge_rdata.gtot,
                                 bin_hit: 8'd0, gap_counted: 1'b0, bin_count: 32'd0};
                end
            end
            eiah_pkg::ST_GAP:
            begin
                gtot_reg <= gtot_reg + gap_reg;
            end
            eiah_pkg::ST_DIV:
            begin
                hit_reg <= div_q;
            end
            eiah_pkg::ST_BRD:
            begin
                res_reg <= '{traversal_total: cnt_reg, gap_sum: gtot_reg,
                             bin_hit: 8'(hit_reg), gap_counted: 1'b1,
                             bin_count: hit_sum};
            end
            default:
            begin
            end
        endcase
    end

    assign done   = (state_reg == eiah_pkg::ST_DONE);
    assign result = res_reg;

    eiah_ram #(
        .W ($bits(eiah_pkg::edge_entry_t)),
        .D (NUM_EDGES),
        .AW(EAW)
    ) u_edge_ram (
        .clk  (clk),
        .we   (edge_we),
        .waddr(edge_waddr),
        .wdata(edge_wdata),
        .raddr(edge_raddr),
        .rdata(edge_rdata)
    );

    eiah_ram #(
        .W (32),
        .D (BIN_DEPTH),
        .AW(BAW)
    ) u_bin_ram (
        .clk  (clk),
        .we   (bin_we),
        .waddr(bin_waddr),
        .wdata(bin_wdata),
        .raddr(bin_raddr),
        .rdata(bin_rdata)
    );

    eiah_div #(
        .QW(BNW),
        .DW(8)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(capped),
        .divisor (w_eff),
        .done    (div_done),
        .quotient(div_q)
    );

`ifndef SYNTHESIS
    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("result strobe not followed by idle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not make the unit busy");

    a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == eiah_pkg::ST_DIV && div_done) |-> (32'(div_q) <= MAX_GAP))
        else $error("bin index beyond the overflow bin");

    a_bin0_split: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == eiah_pkg::ST_B0) |-> (hit_reg != '0))
        else $error("bin zero update overlaps the hit bin");
`endif

endmodule
`default_nettype wire
